FILE: hdl/mrgc_pkg.sv
// Shared types and constants for the mixed-radix Gray counter.
`timescale 1ns / 1ps
package mrgc_pkg;

  localparam int RANK_W       = 64;
  localparam int CODE_W       = 64;
  localparam int LIMIT_STRIDE = 8;
  localparam int LIMITS_W     = 64;
  localparam int OUT_TDATA_W  = 72;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DIV    = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  // Per-cycle commands that every digit cell sees.
  typedef struct packed {
    logic step_en;
    logic shift_en;
    logic commit;
  } cell_ctrl_t;

endpackage

FILE: hdl/mrgc_cell.sv
// One digit cell: value, direction, load staging and the step and reflect chains.
`timescale 1ns / 1ps
module mrgc_cell #(
  parameter int DIGIT_WIDTH = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mrgc_pkg::cell_ctrl_t   ctrl,
  input  logic [DIGIT_WIDTH-1:0] limit,
  input  logic                   end_in,
  output logic                   end_out,
  input  logic                   any_move,
  input  logic [DIGIT_WIDTH-1:0] stage_in,
  output logic [DIGIT_WIDTH-1:0] stage_out,
  input  logic                   refl_in,
  output logic                   refl_out,
  output logic [DIGIT_WIDTH-1:0] value_nxt
);
  import mrgc_pkg::*;

  logic [DIGIT_WIDTH-1:0] val_r, val_nxt;
  logic                   dir_r, dir_nxt;
  logic [DIGIT_WIDTH-1:0] stage_r;
  logic                   self_end;
  logic [DIGIT_WIDTH-1:0] eff;

  // A digit counting up is at its end once it reaches or passes its limit.
  assign self_end = dir_r ? (val_r == '0) : (val_r >= limit);
  assign end_out  = end_in & self_end;

  // Reflection passes down from the top digit; two reflections cancel out.
  assign eff      = refl_in ? DIGIT_WIDTH'(limit - stage_r) : stage_r;
  assign refl_out = refl_in ^ eff[0];

  assign stage_out = stage_r;
  assign value_nxt = val_nxt;

  always_comb begin
    val_nxt = val_r;
    dir_nxt = dir_r;
    if (ctrl.commit) begin
      val_nxt = eff;
      dir_nxt = refl_in;
    end else if (ctrl.step_en) begin
      if (end_in && !self_end) begin
        val_nxt = dir_r ? DIGIT_WIDTH'(val_r - DIGIT_WIDTH'(1))
                        : DIGIT_WIDTH'(val_r + DIGIT_WIDTH'(1));
      end else if (end_out && any_move) begin
        dir_nxt = ~dir_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
      dir_r <= 1'b0;
    end else begin
      val_r <= val_nxt;
      dir_r <= dir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift_en) begin
      stage_r <= stage_in;
    end
  end

endmodule

FILE: hdl/mrgc_div.sv
// Bit-serial restoring divider that peels one mixed-radix digit off the rank.
`timescale 1ns / 1ps
module mrgc_div #(
  parameter int DIGIT_WIDTH = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        en,
  input  logic [mrgc_pkg::RANK_W-1:0] dividend,
  input  logic [DIGIT_WIDTH:0]        radix,
  output logic                        last,
  output logic [DIGIT_WIDTH-1:0]      digit,
  output logic [mrgc_pkg::RANK_W-1:0] quotient
);
  import mrgc_pkg::*;

  localparam int CNT_W = $clog2(RANK_W);

  logic [RANK_W-1:0]    q_r, q_nxt;
  logic [DIGIT_WIDTH:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]     cnt_r;
  logic [DIGIT_WIDTH+1:0] trial;
  logic                 ge;

  assign trial   = {rem_r, q_r[RANK_W-1]};
  assign ge      = trial >= {1'b0, radix};
  assign rem_nxt = ge ? (DIGIT_WIDTH+1)'(trial - {1'b0, radix})
                      : trial[DIGIT_WIDTH:0];
  assign q_nxt   = {q_r[RANK_W-2:0], ge};

  assign last     = (cnt_r == CNT_W'(RANK_W - 1));
  assign digit    = rem_nxt[DIGIT_WIDTH-1:0];
  assign quotient = q_r;

  // The quotient of one digit stays in place as the dividend of the next.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= '0;
    end else if (en) begin
      cnt_r <= CNT_W'(cnt_r + CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (en) begin
      q_r   <= q_nxt;
      rem_r <= last ? '0 : rem_nxt;
    end
  end

endmodule

FILE: hdl/mixed_radix_gray_counter_core.sv
// Top level of the mixed-radix reflected Gray code counter.
`timescale 1ns / 1ps
// A step command (tuser 0) is applied in the cycle it is accepted: the digit
// cells pass an "at end" flag up their chain, the lowest digit that can move
// does so and all digits below it turn round, so steps are taken in every
// cycle while the result side keeps up. A load command (tuser 1) runs the rank
// through a bit-serial divider, one digit after another for each of the
// NUM_DIGITS digits, and the digits shift down the cells as they come out;
// the ST_FINISH state reflects them and writes the result beat, and no new
// beat is taken until the load is through. A rank beyond the number of
// codes leaves the counter as it was and flags rank_error.
module mixed_radix_gray_counter_core #(
  parameter int NUM_DIGITS  = 8,
  parameter int DIGIT_WIDTH = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [mrgc_pkg::LIMITS_W-1:0]    cfg_wr_data,   // digit_limits
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [mrgc_pkg::RANK_W-1:0]      in_tdata,      // start_rank
  input  logic                             in_tuser,      // func
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [mrgc_pkg::OUT_TDATA_W-1:0] out_tdata      // code_digits, advanced, rank_error
);
  import mrgc_pkg::*;

  localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  state_t state_r, state_nxt;
  logic [LIMITS_W-1:0]  limits_r;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0]    out_code_r;
  logic                 out_adv_r, out_err_r;

  logic                 in_fire, out_load, load_adv, load_err;
  logic                 div_start, div_en, div_last;
  logic [DIGIT_WIDTH-1:0] div_digit;
  logic [RANK_W-1:0]    div_quo;
  logic                 rank_err;
  cell_ctrl_t           ctrl;

  logic [DIGIT_WIDTH-1:0] limit_a [NUM_DIGITS];
  logic [DIGIT_WIDTH-1:0] digit_nxt [NUM_DIGITS];
  logic                   end_c [NUM_DIGITS+1];
  logic [DIGIT_WIDTH-1:0] stage_c [NUM_DIGITS+1];
  logic                   refl_c [NUM_DIGITS+1];
  logic                   any_move;
  logic [CODE_W-1:0]      code_nxt;

  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;

  assign end_c[0]          = 1'b1;
  assign any_move          = ~end_c[NUM_DIGITS];
  assign stage_c[NUM_DIGITS] = div_digit;
  assign refl_c[NUM_DIGITS]  = 1'b0;

  genvar gi;
  generate
    for (gi = 0; gi < NUM_DIGITS; gi++) begin : g_cell
      assign limit_a[gi] = limits_r[gi*LIMIT_STRIDE +: DIGIT_WIDTH];
      mrgc_cell #(
        .DIGIT_WIDTH(DIGIT_WIDTH)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .limit    (limit_a[gi]),
        .end_in   (end_c[gi]),
        .end_out  (end_c[gi+1]),
        .any_move (any_move),
        .stage_in (stage_c[gi+1]),
        .stage_out(stage_c[gi]),
        .refl_in  (refl_c[gi+1]),
        .refl_out (refl_c[gi]),
        .value_nxt(digit_nxt[gi])
      );
    end
  endgenerate

  mrgc_div #(
    .DIGIT_WIDTH(DIGIT_WIDTH)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .en      (div_en),
    .dividend(in_tdata),
    .radix   ({1'b0, limit_a[idx_r]} + (DIGIT_WIDTH+1)'(1)),
    .last    (div_last),
    .digit   (div_digit),
    .quotient(div_quo)
  );

  always_comb begin
    code_nxt = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      code_nxt[i*LIMIT_STRIDE +: DIGIT_WIDTH] = digit_nxt[i];
    end
  end

  // Anything left over after the top digit means the rank is out of range.
  assign rank_err = (div_quo != '0);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    ctrl          = '0;
    div_start     = 1'b0;
    div_en        = 1'b0;
    out_load      = 1'b0;
    load_adv      = 1'b0;
    load_err      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser) begin
            div_start = 1'b1;
            idx_nxt   = '0;
            state_nxt = ST_DIV;
          end else begin
            ctrl.step_en = 1'b1;
            out_load     = 1'b1;
            load_adv     = any_move;
          end
        end
      end
      ST_DIV: begin
        div_en = 1'b1;
        if (div_last) begin
          ctrl.shift_en = 1'b1;
          if (idx_r == IDX_W'(NUM_DIGITS - 1)) begin
            state_nxt = ST_FINISH;
          end else begin
            idx_nxt = IDX_W'(idx_r + IDX_W'(1));
          end
        end
      end
      ST_FINISH: begin
        ctrl.commit = ~rank_err;
        out_load    = 1'b1;
        load_err    = rank_err;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      limits_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        limits_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_code_r <= code_nxt;
      out_adv_r  <= load_adv;
      out_err_r  <= load_err;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - CODE_W - 2){1'b0}}, out_err_r, out_adv_r, out_code_r};

endmodule
